>>> design/fta_pkg.sv
package fta_pkg;

  localparam int SIZE_W = 20;
  localparam int FS_W = 17;
  localparam int PID_W = 16;
  localparam int PAGE_W = 5;
  localparam int FIDX_W = 5;
  localparam int CNT_W = 6;
  localparam int FIC_W = 6;
  localparam int DIV_STEPS = SIZE_W;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic REG_FRAME_SIZE = 1'b0;
  localparam logic REG_FRAMES_IN_USE = 1'b1;

  localparam logic [FS_W-1:0] FRAME_SIZE_RST = 17'd1024;
  localparam logic [FIC_W-1:0] FRAMES_IN_USE_RST = 6'd32;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } fta_state_t;

  typedef struct packed {
    logic latch_in;
    logic div_start;
    logic scan_start;
    logic finish;
  } fta_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic div_done;
    logic no_mem;
    logic scan_done;
    logic out_free;
  } fta_stat_t;

endpackage

>>> design/frame_table_allocator.sv
// Frame table allocator (inverted page table), one entry per physical frame.
// Input channel in_*: one request word per handshake; in_tuser carries the
// request kind (allocate, deallocate, look up), in_tdata the process id,
// process size and page number. Output channel out_*: one result word per
// request; out_tuser carries the status, out_tdata frame index and count.
// Config channel cfg_*: index 0 frame size, index 1 frames in use; a write
// clears the table and reloads the free count. Write only while idle.
// Allocate first divides the process size by the frame size for the page
// count, then scans the table over the managed frames unless too few are
// free; deallocate and lookup go straight to the table scan.
// One request is in work at a time; the next is taken once the current
// one has reached the output register.
// Reset: table empty, frame size 1024, frames in use 32 (clamped to
// NUM_FRAMES), free count equal to frames in use.
// A stalled receiver holds the result in the output register; a new
// request may still be accepted and runs until its result is ready.
module frame_table_allocator
  import fta_pkg::*;
#(
  parameter int NUM_FRAMES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // process_id, process_size, page_number
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // frame_index, page_count
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  fta_cmd_t  cmd;
  fta_stat_t stat;
  logic      idle;

  fta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .cmd       (cmd),
    .idle      (idle)
  );

  fta_dpath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign in_tready = idle;
  assign cfg_ready = idle && !in_tvalid;

endmodule

>>> design/fta_div.sv
module fta_div
  import fta_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [FS_W-1:0]   divisor,
  output logic              done,
  output logic [SIZE_W-1:0] quo,
  output logic [FS_W-1:0]   rem
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] quo_r, quo_nxt;
  logic [FS_W-1:0]   rem_r, rem_nxt;
  logic [FS_W-1:0]   dvs_r, dvs_nxt;
  logic [FS_W:0]     shifted;
  logic [FS_W+1:0]   diff;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, quo_r[SIZE_W-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[FS_W+1]) begin
        rem_nxt = diff[FS_W-1:0];
        quo_nxt = {quo_r[SIZE_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[FS_W-1:0];
        quo_nxt = {quo_r[SIZE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

>>> design/fta_dpath.sv
module fta_dpath
  import fta_pkg::*;
#(
  parameter int NUM_FRAMES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fta_cmd_t    cmd,
  output fta_stat_t   stat,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int NW = (CW > FIC_W) ? CW : FIC_W;

  function automatic logic [CW-1:0] eff_frames(input logic [FIC_W-1:0] v);
    logic [NW-1:0] e;
    e = NW'(v);
    if (e == '0) e = NW'(1);
    else if (e > NW'(NUM_FRAMES)) e = NW'(NUM_FRAMES);
    return CW'(e);
  endfunction

  logic [FS_W-1:0]   fsize_r, fsize_nxt;
  logic [FIC_W-1:0]  fuse_r, fuse_nxt;
  logic [CW-1:0]     free_r, free_nxt;
  logic [NUM_FRAMES-1:0] valid_r, valid_nxt;

  logic [1:0]        kind_r;
  logic [PID_W-1:0]  pid_r;
  logic [PAGE_W-1:0] page_r;
  logic              no_mem_r;

  logic              s1_act_r, s1_act_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              s2_vld_r;
  logic [IW-1:0]     s2_idx_r;
  logic [PID_W-1:0]  own_q_r;
  logic [PAGE_W-1:0] pg_q_r;

  logic [CW-1:0]     next_r, next_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     fidx_r, fidx_nxt;

  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic [1:0]        out_user_r;

  logic [PID_W-1:0]  own_mem [NUM_FRAMES];
  logic [PAGE_W-1:0] page_mem [NUM_FRAMES];

  logic [FS_W-1:0]   fs_eff;
  logic [CW-1:0]     n_eff;
  logic [IW-1:0]     n_last;
  logic              div_done;
  logic [SIZE_W-1:0] quo;
  logic [FS_W-1:0]   rem;
  logic [SIZE_W:0]   need;
  logic              cur_v;
  logic              own_hit;
  logic              mem_we;
  logic [CW:0]       free_sum;
  logic [1:0]        res_status;
  logic [IW-1:0]     res_idx;
  logic [CW-1:0]     res_cnt;
  logic [IW+FIDX_W-1:0] idx_ext;
  logic [CW+CNT_W-1:0]  cnt_ext;
  logic [CW+PAGE_W-1:0] pg_ext;

  assign fs_eff = (fsize_r == '0) ? FS_W'(1) : fsize_r;
  assign n_eff  = eff_frames(fuse_r);
  assign n_last = IW'(n_eff - 1'b1);

  fta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (in_tdata[35:16]),
    .divisor  (fs_eff),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  assign need = (SIZE_W + 1)'(quo) + (SIZE_W + 1)'(rem != '0);

  assign stat.is_alloc  = (in_tuser == KIND_ALLOC);
  assign stat.div_done  = div_done;
  assign stat.no_mem    = need > (SIZE_W + 1)'(free_r);
  assign stat.scan_done = s2_vld_r && (s2_idx_r == n_last);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign cur_v   = valid_r[s2_idx_r];
  assign own_hit = cur_v && (own_q_r == pid_r);
  assign pg_ext  = (CW + PAGE_W)'(next_r);
  assign mem_we  = s2_vld_r && (kind_r == KIND_ALLOC) && !cur_v &&
                   ((SIZE_W + 1)'(next_r) < need);

  always_comb begin
    fsize_nxt  = fsize_r;
    fuse_nxt   = fuse_r;
    free_nxt   = free_r;
    valid_nxt  = valid_r;
    s1_act_nxt = s1_act_r;
    idx_nxt    = idx_r;
    next_nxt   = next_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    fidx_nxt   = fidx_r;
    free_sum   = {1'b0, free_r} + {1'b0, cnt_r};

    if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_SIZE: begin
          fsize_nxt = cfg_data;
        end
        REG_FRAMES_IN_USE: begin
          fuse_nxt = cfg_data[FIC_W-1:0];
        end
        default: begin
        end
      endcase
      valid_nxt = '0;
      free_nxt  = eff_frames(fuse_nxt);
    end

    if (cmd.scan_start) begin
      s1_act_nxt = 1'b1;
      idx_nxt    = '0;
      next_nxt   = '0;
      cnt_nxt    = '0;
      found_nxt  = 1'b0;
      fidx_nxt   = '0;
    end else if (s1_act_r) begin
      if (idx_r == n_last) s1_act_nxt = 1'b0;
      else idx_nxt = idx_r + 1'b1;
    end

    if (s2_vld_r) begin
      case (kind_r)
        KIND_ALLOC: begin
          if (mem_we) begin
            valid_nxt[s2_idx_r] = 1'b1;
            next_nxt = next_r + 1'b1;
          end
        end
        KIND_FREE: begin
          if (own_hit) begin
            valid_nxt[s2_idx_r] = 1'b0;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        KIND_LOOKUP: begin
          if (!found_r && own_hit && (pg_q_r == page_r)) begin
            found_nxt = 1'b1;
            fidx_nxt  = s2_idx_r;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.finish) begin
      if (kind_r == KIND_ALLOC && !no_mem_r) begin
        free_nxt = free_r - next_r;
      end else if (kind_r == KIND_FREE) begin
        if (free_sum > {1'b0, n_eff}) free_nxt = n_eff;
        else free_nxt = free_sum[CW-1:0];
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_cnt    = '0;
    case (kind_r)
      KIND_ALLOC: begin
        if (no_mem_r) res_status = ST_NOMEM;
        else res_cnt = next_r;
      end
      KIND_FREE: begin
        res_cnt = cnt_r;
      end
      KIND_LOOKUP: begin
        if (found_r) res_idx = fidx_r;
        else res_status = ST_NOTFOUND;
      end
      default: begin
      end
    endcase
    idx_ext = (IW + FIDX_W)'(res_idx);
    cnt_ext = (CW + CNT_W)'(res_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r     <= FRAME_SIZE_RST;
      fuse_r      <= FRAMES_IN_USE_RST;
      free_r      <= eff_frames(FRAMES_IN_USE_RST);
      valid_r     <= '0;
      s1_act_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fsize_r     <= fsize_nxt;
      fuse_r      <= fuse_nxt;
      free_r      <= free_nxt;
      valid_r     <= valid_nxt;
      s1_act_r    <= s1_act_nxt;
      s2_vld_r    <= s1_act_r;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    idx_r    <= idx_nxt;
    s2_idx_r <= idx_r;
    next_r   <= next_nxt;
    cnt_r    <= cnt_nxt;
    found_r  <= found_nxt;
    fidx_r   <= fidx_nxt;
    if (cmd.latch_in) begin
      kind_r   <= in_tuser;
      pid_r    <= in_tdata[15:0];
      page_r   <= in_tdata[40:36];
      no_mem_r <= 1'b0;
    end else if (div_done) begin
      no_mem_r <= stat.no_mem;
    end
    if (cmd.finish) begin
      out_user_r <= res_status;
      out_data_r <= {5'b0, cnt_ext[CNT_W-1:0], idx_ext[FIDX_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_act_r) begin
      own_q_r <= own_mem[idx_r];
      pg_q_r  <= page_mem[idx_r];
    end
    if (mem_we) begin
      own_mem[s2_idx_r]  <= pid_r;
      page_mem[s2_idx_r] <= pg_ext[PAGE_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= n_eff)
    else $error("free count above managed frames");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished word not presented");
`endif

endmodule

>>> design/fta_ctrl.sv
module fta_ctrl
  import fta_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  fta_stat_t stat,
  output fta_cmd_t  cmd,
  output logic      idle
);

  fta_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          if (stat.is_alloc) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (stat.no_mem) begin
            state_nxt = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign idle = (state_r == S_IDLE);

`ifndef SYNTH
  a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scan_done |-> state_r == S_SCAN)
    else $error("scan end outside scan state");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> state_r == S_DIV)
    else $error("divide end outside divide state");
`endif

endmodule
